[sv/i2c_master_bit_engine_top_macros.svh]
// Assertion helpers shared by the checker.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH

// Condition holds on every edge out of reset.
`define CHK_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed");

// Antecedent implies consequent on the following edge, out of reset.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

// As above, but also watched while reset is high.
`define CHK_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[sv/i2cm_pkg.sv]
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int BYTE_BITS       = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;

  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_WAIT
  } cmd_class_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_SP0, PH_SP1, PH_SP2,
    PH_WD, PH_WH, PH_WL, PH_RL, PH_RH, PH_AK0, PH_AK1, PH_KW0, PH_KW1
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_line;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       timeout_error;
  } rsp_t;

  typedef struct packed {
    cmd_class_t cls;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_line;
  } qent_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_timeout_ticks;
  } cfg_t;

endpackage

[sv/i2cm_front.sv]
`timescale 1ns / 1ps
module i2cm_front import i2cm_pkg::*; (
  input  req_t  req,
  output qent_t entry
);

  // Decode opcode into a command class; undefined codes become no-ops.
  always_comb begin
    entry.tx_byte  = req.tx_byte;
    entry.send_ack = req.send_ack;
    entry.sda_line = req.sda_line;
    entry.cls      = CMD_NONE;
    if (req.cmd_valid) begin
      case (req.opcode)
        OP_START: entry.cls = CMD_START;
        OP_STOP:  entry.cls = CMD_STOP;
        OP_WRITE: entry.cls = CMD_WRITE;
        OP_READ:  entry.cls = CMD_READ;
        OP_WAIT:  entry.cls = CMD_WAIT;
        default:  entry.cls = CMD_NONE;
      endcase
    end
  end

endmodule

[sv/i2cm_queue.sv]
`timescale 1ns / 1ps
module i2cm_queue import i2cm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output qent_t head
);

  qent_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[sv/i2cm_back.sv]
`timescale 1ns / 1ps
module i2cm_back import i2cm_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_nonempty,
  input  qent_t q_head,
  output logic  q_pop,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output rsp_t  rsp_word
);

  localparam int CW = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;

  phase_t                 phase, phase_next;
  logic [TIMER_WIDTH-1:0] timer, timer_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [7:0]             ack_wait, ack_wait_next;
  logic                   ack_choice, ack_choice_next;
  logic                   scl, scl_next;
  logic                   sda, sda_next;
  logic                   drive, drive_next;
  logic [7:0]             rx, rx_next;
  logic                   ack_seen, ack_seen_next;
  logic                   tmo, tmo_next;
  logic                   done;

  logic [15:0] limit;
  logic        seg_end;
  logic [3:0]  bc_inc;

  assign q_pop   = q_nonempty && (!rsp_valid || !rsp_stall);
  assign limit   = (cfg.phase_ticks == '0) ? 16'd1 : cfg.phase_ticks;
  assign seg_end = ((CW'(timer) + CW'(1)) >= CW'(limit)) || (&timer);
  assign bc_inc  = bit_count + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      timer      <= '0;
      bit_count  <= '0;
      shift_reg  <= '0;
      ack_wait   <= '0;
      ack_choice <= 1'b0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      drive      <= 1'b1;
      rx         <= '0;
      ack_seen   <= 1'b0;
      tmo        <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (q_pop) begin
        phase      <= phase_next;
        timer      <= timer_next;
        bit_count  <= bit_count_next;
        shift_reg  <= shift_reg_next;
        ack_wait   <= ack_wait_next;
        ack_choice <= ack_choice_next;
        scl        <= scl_next;
        sda        <= sda_next;
        drive      <= drive_next;
        rx         <= rx_next;
        ack_seen   <= ack_seen_next;
        tmo        <= tmo_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result register: loaded with the post-step levels.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rsp_word.scl_level     <= scl_next;
      rsp_word.sda_level     <= sda_next;
      rsp_word.sda_drive     <= drive_next;
      rsp_word.busy_res      <= (phase_next != PH_IDLE);
      rsp_word.done_res      <= done;
      rsp_word.rx_byte       <= rx_next;
      rsp_word.ack_seen      <= ack_seen_next;
      rsp_word.timeout_error <= tmo_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    timer_next      = timer;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    ack_wait_next   = ack_wait;
    ack_choice_next = ack_choice;
    scl_next        = scl;
    sda_next        = sda;
    drive_next      = drive;
    rx_next         = rx;
    ack_seen_next   = ack_seen;
    tmo_next        = tmo;
    done            = 1'b0;

    if (phase == PH_IDLE) begin
      if (q_head.cls != CMD_NONE) begin
        timer_next     = '0;
        bit_count_next = '0;
      end
      case (q_head.cls)
        CMD_START: begin
          drive_next = 1'b1;
          sda_next   = 1'b1;
          scl_next   = 1'b1;
          phase_next = PH_ST0;
        end
        CMD_STOP: begin
          drive_next = 1'b1;
          sda_next   = 1'b0;
          scl_next   = 1'b0;
          phase_next = PH_SP0;
        end
        CMD_WRITE: begin
          drive_next     = 1'b1;
          scl_next       = 1'b0;
          sda_next       = q_head.tx_byte[7];
          shift_reg_next = {q_head.tx_byte[6:0], 1'b0};
          phase_next     = PH_WD;
        end
        CMD_READ: begin
          drive_next      = 1'b0;
          scl_next        = 1'b0;
          shift_reg_next  = '0;
          ack_choice_next = q_head.send_ack;
          phase_next      = PH_RL;
        end
        CMD_WAIT: begin
          drive_next    = 1'b0;
          sda_next      = 1'b1;
          ack_wait_next = '0;
          phase_next    = PH_KW0;
        end
        default: ;
      endcase
    end else if (phase == PH_KW1) begin
      if (!q_head.sda_line) begin
        scl_next      = 1'b0;
        ack_seen_next = 1'b1;
        tmo_next      = 1'b0;
        phase_next    = PH_IDLE;
        done          = 1'b1;
      end else if (ack_wait >= cfg.ack_timeout_ticks) begin
        ack_seen_next = 1'b0;
        tmo_next      = 1'b1;
        drive_next    = 1'b1;
        sda_next      = 1'b0;
        scl_next      = 1'b0;
        timer_next    = '0;
        phase_next    = PH_SP0;
      end else begin
        ack_wait_next = ack_wait + 8'd1;
      end
    end else if (!seg_end) begin
      timer_next = timer + 1'b1;
    end else begin
      timer_next = '0;
      case (phase)
        PH_ST0: begin sda_next = 1'b0; phase_next = PH_ST1; end
        PH_ST1: begin scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1; end
        PH_SP0: begin scl_next = 1'b1; phase_next = PH_SP1; end
        PH_SP1: begin sda_next = 1'b1; phase_next = PH_SP2; end
        PH_SP2: begin phase_next = PH_IDLE; done = 1'b1; end
        PH_WD:  begin scl_next = 1'b1; phase_next = PH_WH; end
        PH_WH:  begin scl_next = 1'b0; phase_next = PH_WL; end
        PH_WL: begin
          bit_count_next = bc_inc;
          if (bc_inc >= 4'(BYTE_BITS)) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            sda_next       = shift_reg[7];
            shift_reg_next = {shift_reg[6:0], 1'b0};
            phase_next     = PH_WD;
          end
        end
        PH_RL: begin scl_next = 1'b1; phase_next = PH_RH; end
        PH_RH: begin
          shift_reg_next = {shift_reg[6:0], q_head.sda_line};
          bit_count_next = bc_inc;
          scl_next       = 1'b0;
          if (bc_inc >= 4'(BYTE_BITS)) begin
            drive_next = 1'b1;
            sda_next   = ~ack_choice;
            phase_next = PH_AK0;
          end else begin
            phase_next = PH_RL;
          end
        end
        PH_AK0: begin scl_next = 1'b1; phase_next = PH_AK1; end
        PH_AK1: begin
          scl_next   = 1'b0;
          sda_next   = 1'b1;
          rx_next    = shift_reg;
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
        PH_KW0: begin
          scl_next      = 1'b1;
          ack_wait_next = '0;
          phase_next    = PH_KW1;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

endmodule

[sv/i2c_master_bit_engine_top.sv]
`timescale 1ns / 1ps
// I2C master bit engine: one request word is one bus tick.
// Request channel (req_valid / req_stall / req_word): each word carries an
//   optional command (start, stop, write byte, read byte + ack, wait ack)
//   and the sampled SDA level for that tick. Commands offered while a
//   command is running, or with an undefined opcode, are ignored.
// Response channel (rsp_valid / rsp_stall / rsp_word): exactly one word per
//   request word, in order: SCL/SDA levels and SDA enable after the tick,
//   busy, a done pulse, last received byte and the ack/timeout flags.
// Config port (APB style, always ready): 0x0 phase_ticks, 0x4
//   ack_timeout_ticks. Write only while no words are in flight.
// Path: an accepted word enters the queue; its response is registered when popped.
// Throughput: one word per cycle while the response is not stalled, set by
//   the back-end sequencer step, which updates all bus state once per popped word.
// Reset (synchronous): bus released (SCL, SDA high, SDA driven), queue
//   empty, no response pending, config back to 5 and 250.
// Response stall: the response register holds; request words collect in a
//   four-deep queue, and req_stall rises once it is full.
module i2c_master_bit_engine_top import i2cm_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_word,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  qent_t front_entry;
  qent_t q_head;
  logic  q_full;
  logic  q_nonempty;
  logic  q_pop;
  logic  cfg_wr;

  // Register file: word index is address bit 2, low bits ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks       <= 16'd5;
      cfg.ack_timeout_ticks <= 8'd250;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PHASE_TICKS) cfg.phase_ticks <= pwdata[15:0];
      else                             cfg.ack_timeout_ticks <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_PHASE_TICKS) ? {16'd0, cfg.phase_ticks}
                                                : {24'd0, cfg.ack_timeout_ticks};

  // Front end: classify the command of every word.
  i2cm_front u_front (
    .req   (req_word),
    .entry (front_entry)
  );

  // Short queue decouples acceptance from the sequencer and result stall.
  assign req_stall = q_full;

  i2cm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid && !q_full),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // Back end: bus sequencer and response register.
  i2cm_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_word   (rsp_word)
  );

endmodule

[sv/i2cm_checker.sv]
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_top_macros.svh"
module i2cm_checker import i2cm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input rsp_t        rsp_word
);

  // A held response keeps its word.
  `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
  // Completion always leaves the sequencer idle.
  `CHK_ALWAYS(a_done_idle, !(rsp_valid && rsp_word.done_res && rsp_word.busy_res))
  // Ack and timeout flags are never set together.
  `CHK_ALWAYS(a_flags_excl, !(rsp_valid && rsp_word.ack_seen && rsp_word.timeout_error))
  // Nothing is pending straight after reset.
  `CHK_NEXT_RST(a_rst_empty, rst, !rsp_valid && !req_stall)

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_chk (.*);
